[sv/ttst_pkg.sv]
// Shared types, constant tables and the control program of the torque table step tracker.
// Depends on nothing; the sequencer, the datapath and the top level import it.
package ttst_pkg;

  localparam int SPEED_POINTS = 14;
  localparam int WIND_COLUMNS = 3;
  localparam int SEG_W        = 4;   // holds segment indexes 0 .. SPEED_POINTS-2
  localparam int COL_W        = 2;   // holds column indexes 0 .. WIND_COLUMNS-1
  localparam int TQ_LEN       = SPEED_POINTS * WIND_COLUMNS;
  localparam int TQ_IDX_W     = 6;
  localparam int STEP_W       = 4;

  localparam logic [15:0] SETPOINT_RESET = 16'd1024;
  localparam logic [14:0] TORQUE_STEP_RESET = 15'd102;

  // Rotor speed breakpoints, unsigned Q10.6.
  localparam logic [15:0] BP_TABLE [0:SPEED_POINTS-1] = '{
    16'd1,     16'd3200,  16'd6400,  16'd9600,  16'd12800, 16'd16000, 16'd19200,
    16'd22400, 16'd25600, 16'd28800, 16'd32000, 16'd35200, 16'd38400, 16'd41600
  };

  // Torque curves, signed Q6.10, one row per breakpoint, columns for 1, 2 and 3 m/s.
  localparam logic signed [15:0] TQ_TABLE [0:TQ_LEN-1] = '{
       16'sd109,    16'sd432,    16'sd972,
       16'sd276,   16'sd1393,   16'sd1628,
        -16'sd5,   16'sd1106,   16'sd3635,
      -16'sd348,    16'sd504,   16'sd2488,
     -16'sd1260,    -16'sd18,   16'sd1526,
     -16'sd2314,   -16'sd579,    16'sd737,
     -16'sd3318,  -16'sd1393,    -16'sd48,
     -16'sd4772,  -16'sd2949,   -16'sd869,
     -16'sd6298,  -16'sd5120,  -16'sd1751,
     -16'sd7987,  -16'sd6697,  -16'sd3133,
     -16'sd9933,  -16'sd9247,  -16'sd4925,
    -16'sd12083, -16'sd10752,  -16'sd9359,
    -16'sd14336, -16'sd13210, -16'sd11776,
    -16'sd16794, -16'sd16077, -16'sd14848
  };

  // Datapath operations.
  localparam logic [3:0] OP_NONE    = 4'd0;
  localparam logic [3:0] OP_ACCEPT  = 4'd1;
  localparam logic [3:0] OP_SEARCH  = 4'd2;
  localparam logic [3:0] OP_MUL     = 4'd3;
  localparam logic [3:0] OP_DIVINIT = 4'd4;
  localparam logic [3:0] OP_DIV     = 4'd5;
  localparam logic [3:0] OP_REF     = 4'd6;
  localparam logic [3:0] OP_UPDATE  = 4'd7;
  localparam logic [3:0] OP_NOMATCH = 4'd8;
  localparam logic [3:0] OP_OUT     = 4'd9;

  // Jump conditions.
  localparam logic [2:0] C_NEVER    = 3'd0;
  localparam logic [2:0] C_ALWAYS   = 3'd1;
  localparam logic [2:0] C_NO_IN    = 3'd2;
  localparam logic [2:0] C_BAD_WIND = 3'd3;
  localparam logic [2:0] C_SCAN     = 3'd4;
  localparam logic [2:0] C_NO_HIT   = 3'd5;
  localparam logic [2:0] C_DEGEN    = 3'd6;
  localparam logic [2:0] C_BUSY_DIV = 3'd7;

  // Program steps.
  localparam logic [STEP_W-1:0] S_IDLE     = 4'd0;
  localparam logic [STEP_W-1:0] S_WIND     = 4'd1;
  localparam logic [STEP_W-1:0] S_SEARCH   = 4'd2;
  localparam logic [STEP_W-1:0] S_SEND     = 4'd3;
  localparam logic [STEP_W-1:0] S_MUL      = 4'd4;
  localparam logic [STEP_W-1:0] S_DIVINIT  = 4'd5;
  localparam logic [STEP_W-1:0] S_DIV      = 4'd6;
  localparam logic [STEP_W-1:0] S_REF      = 4'd7;
  localparam logic [STEP_W-1:0] S_UPDATE   = 4'd8;
  localparam logic [STEP_W-1:0] S_NOMATCH  = 4'd9;
  localparam logic [STEP_W-1:0] S_OUT_WAIT = 4'd10;
  localparam logic [STEP_W-1:0] S_OUT      = 4'd11;

  typedef struct packed {
    logic [3:0]        op;
    logic [2:0]        cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // Status from the datapath that the jump conditions test.
  typedef struct packed {
    logic bad_wind;
    logic scan;
    logic no_hit;
    logic degen;
    logic div_more;
    logic out_busy;
  } flags_t;

  // The control program. A word that jumps on its condition goes to target,
  // otherwise to the next step. The divide loop and the output wait share
  // one condition code: each step tests the flag that applies to it.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    case (step)
      S_IDLE:     w = '{OP_ACCEPT,  C_NO_IN,    S_IDLE};
      S_WIND:     w = '{OP_NONE,    C_BAD_WIND, S_NOMATCH};
      S_SEARCH:   w = '{OP_SEARCH,  C_SCAN,     S_SEARCH};
      S_SEND:     w = '{OP_NONE,    C_NO_HIT,   S_NOMATCH};
      S_MUL:      w = '{OP_MUL,     C_DEGEN,    S_REF};
      S_DIVINIT:  w = '{OP_DIVINIT, C_NEVER,    S_IDLE};
      S_DIV:      w = '{OP_DIV,     C_BUSY_DIV, S_DIV};
      S_REF:      w = '{OP_REF,     C_NEVER,    S_IDLE};
      S_UPDATE:   w = '{OP_UPDATE,  C_ALWAYS,   S_OUT_WAIT};
      S_NOMATCH:  w = '{OP_NOMATCH, C_NEVER,    S_IDLE};
      S_OUT_WAIT: w = '{OP_NONE,    C_BUSY_DIV, S_OUT_WAIT};
      S_OUT:      w = '{OP_OUT,     C_ALWAYS,   S_IDLE};
      default:    w = '{OP_NONE,    C_ALWAYS,   S_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic signed [15:0] tq_at(input logic [SEG_W-1:0] seg,
                                               input logic [COL_W-1:0] col);
    logic [TQ_IDX_W-1:0] idx;
    idx = TQ_IDX_W'(seg) * TQ_IDX_W'(WIND_COLUMNS) + TQ_IDX_W'(col);
    if (idx < TQ_IDX_W'(TQ_LEN)) begin
      return TQ_TABLE[idx];
    end
    return 16'sd0;
  endfunction

endpackage

[sv/ttst_seq.sv]
// Program sequencer of the torque table step tracker: step counter, control ROM, jumps.
// Depends on ttst_pkg for the control word, the flags and the program.
module ttst_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  input  ttst_pkg::flags_t flags,
  output ttst_pkg::ctrl_t  ctrl
);
  import ttst_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              jump;

  assign ctrl = ucode(step);

  always_comb begin
    case (ctrl.cond)
      C_NEVER:    jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NO_IN:    jump = !s_tvalid;
      C_BAD_WIND: jump = flags.bad_wind;
      C_SCAN:     jump = flags.scan;
      C_NO_HIT:   jump = flags.no_hit;
      C_DEGEN:    jump = flags.degen;
      C_BUSY_DIV: jump = (ctrl.op == OP_DIV) ? flags.div_more : flags.out_busy;
      default:    jump = 1'b0;
    endcase
    step_next = jump ? ctrl.target : step + STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

[sv/ttst_dp.sv]
// Datapath of the torque table step tracker: input latch, segment search, multiplier,
// restoring divider, setpoint update and output register. Depends on ttst_pkg.
module ttst_dp (
  input  logic             clk,
  input  logic             rst,
  input  ttst_pkg::ctrl_t  ctrl,
  input  logic             s_tvalid,
  input  logic [39:0]      s_tdata,
  input  logic             cfg_valid,
  input  logic [14:0]      cfg_data,
  input  logic             m_tready,
  output ttst_pkg::flags_t flags,
  output logic             m_tvalid,
  output logic [31:0]      m_tdata,
  output logic             m_tuser
);
  import ttst_pkg::*;

  logic [3:0]         wind;
  logic [15:0]        speed;
  logic signed [15:0] meas;
  logic [14:0]        torque_step;
  logic signed [15:0] setpoint;
  logic [SEG_W-1:0]   seg;
  logic               hit_reg;
  logic signed [15:0] y1;
  logic               dy_neg;
  logic [15:0]        den;
  logic [32:0]        prod;
  logic               degen;
  logic [15:0]        rem;
  logic [15:0]        dvd;
  logic [3:0]         cnt;
  logic signed [15:0] ref_torque;
  logic               matched;

  logic [COL_W-1:0]   col;
  logic [15:0]        x1;
  logic [15:0]        x2;
  logic               hit;
  logic               last;
  logic signed [16:0] dy;
  logic [16:0]        dy_mag;
  logic [15:0]        t_off;
  logic [32:0]        dividend;
  logic [16:0]        trial;
  logic               ge;
  logic signed [16:0] ref_sum;
  logic signed [16:0] sp_sum;
  logic signed [15:0] sp_sat;

  assign col    = COL_W'(wind - 4'd1);
  assign x1     = BP_TABLE[seg];
  assign x2     = BP_TABLE[seg + SEG_W'(1)];
  assign hit    = (x1 <= speed) && (speed <= x2);
  assign last   = (seg == SEG_W'(SPEED_POINTS - 2));
  assign dy     = 17'(tq_at(seg + SEG_W'(1), col)) - 17'(tq_at(seg, col));
  assign dy_mag = dy[16] ? 17'(-dy) : 17'(dy);
  assign t_off  = speed - x1;

  // The rounding half of the divisor is added before the magnitude division.
  assign dividend = prod + {18'd0, den[15:1]};
  assign trial    = {rem, dvd[15]};
  assign ge       = trial >= {1'b0, den};

  assign ref_sum = dy_neg ? (17'(y1) - {1'b0, dvd}) : (17'(y1) + {1'b0, dvd});

  assign sp_sum = (meas < ref_torque) ? (17'(setpoint) + {2'b00, torque_step})
                                      : (17'(setpoint) - {2'b00, torque_step});
  always_comb begin
    if (sp_sum[16] != sp_sum[15]) begin
      sp_sat = sp_sum[16] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      sp_sat = sp_sum[15:0];
    end
  end

  assign flags.bad_wind = (wind == 4'd0) || (wind > 4'(WIND_COLUMNS));
  assign flags.scan     = !hit && !last;
  assign flags.no_hit   = !hit_reg;
  assign flags.degen    = (x2 == x1);
  assign flags.div_more = (cnt != 4'd15);
  assign flags.out_busy = m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      torque_step <= TORQUE_STEP_RESET;
    end else if (cfg_valid) begin
      torque_step <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint <= SETPOINT_RESET;
    end else if (ctrl.op == OP_UPDATE) begin
      setpoint <= sp_sat;
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_ACCEPT: begin
        if (s_tvalid) begin
          wind    <= s_tdata[3:0];
          speed   <= s_tdata[19:4];
          meas    <= s_tdata[35:20];
          seg     <= '0;
          hit_reg <= 1'b0;
        end
      end
      OP_SEARCH: begin
        if (hit) begin
          hit_reg <= 1'b1;
        end else if (!last) begin
          seg <= seg + SEG_W'(1);
        end
      end
      OP_MUL: begin
        y1     <= tq_at(seg, col);
        dy_neg <= dy[16];
        den    <= x2 - x1;
        prod   <= dy_mag * t_off;
        degen  <= (x2 == x1);
      end
      OP_DIVINIT: begin
        rem <= dividend[31:16];
        dvd <= dividend[15:0];
        cnt <= '0;
      end
      OP_DIV: begin
        rem <= ge ? 16'(trial - {1'b0, den}) : trial[15:0];
        dvd <= {dvd[14:0], ge};
        cnt <= cnt + 4'd1;
      end
      OP_REF: begin
        ref_torque <= degen ? y1 : ref_sum[15:0];
      end
      OP_UPDATE: begin
        matched <= 1'b1;
      end
      OP_NOMATCH: begin
        ref_torque <= 16'sd0;
        matched    <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.op == OP_OUT) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_OUT) begin
      m_tdata <= {ref_torque, setpoint};
      m_tuser <= matched;
    end
  end

endmodule

[sv/torque_table_step_tracker_core.sv]
// Top level of the torque table step tracker: sequencer and datapath.
// Depends on ttst_pkg, ttst_seq and ttst_dp.
//
// Use: an item on the slave channel carries wind speed, rotor speed and
// measured torque. The block picks the torque column of the wind (1 to 3
// m/s), scans the rotor speed breakpoints for the first segment that holds
// the speed, interpolates a reference torque with rounding, and moves its
// kept set torque up or down by the configured step if the item matched.
// One result item per input item leaves on the master channel; m_tuser
// says whether a column and a segment were found.
// Flow: items are handled one at a time by a microcoded sequencer. A
// matched item passes the wind check, the segment scan from segment 0,
// the multiplier, the restoring divider (skipped for a zero-width
// segment), the reference and the setpoint update to a loaded output.
// A wind without a column or a speed outside the table gives an unmatched result.
// The output register holds a result while the next item is accepted and
// processed; if the receiver stalls, the sequencer waits in its output wait step.
// Reset returns the set torque to 1.0, the step to its default and clears
// the result valid flag. Both ready outputs are low during reset.
module torque_table_step_tracker_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // wind_speed[3:0], rotor_speed[19:4], measured_torque[35:20]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // torque_setpoint[15:0], reference_torque[31:16]
  output logic        m_tuser,   // matched[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_data   // torque_step
);
  import ttst_pkg::*;

  ctrl_t  ctrl;
  flags_t flags;

  // An item enters only in the idle step of the program, and never during reset.
  // The step register takes a write at any time outside reset; the sender
  // must write it only while no item is in flight; the block does not enforce this.
  assign s_tready  = !rst && (ctrl.op == OP_ACCEPT);
  assign cfg_ready = !rst;

  ttst_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .flags    (flags),
    .ctrl     (ctrl)
  );

  ttst_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .s_tvalid  (s_tvalid),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tready  (m_tready),
    .flags     (flags),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

[sv/ttst_checker.sv]
// Port-level checks of the torque table step tracker, bound to the top level.
// Depends only on the ports of torque_table_step_tracker_core.
module ttst_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  // A stalled result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // An unmatched result carries a zero reference torque.
  a_unmatched_ref: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[31:16] == 16'd0)
    else $error("unmatched result with nonzero reference");

  // Items are taken one at a time: no item right after an accepted one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after an accepted item");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind torque_table_step_tracker_core ttst_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
